[rtl/watp_pkg.sv]
// Shared constants for the weight allocation transition probability block.
package watp_pkg;

    localparam int MAX_STATES_DEF     = 64;
    localparam int WEIGHT_BITS_DEF    = 24;
    localparam int PROB_FRAC_BITS_DEF = 16;

    // Fixed field widths of the ports
    localparam int STATE_IDX_BITS = 6;
    localparam int CUR_BITS       = 6;

endpackage

[rtl/weight_allocation_transition_probs.sv]
// Weight allocation transition probabilities: loads weights, runs the allocation walk, emits probabilities.
//
// Weights load one per cycle while busy is low; a transaction is accepted when start is high and
// busy is low. The weight marked last closes the set and raises busy. The block then reads the
// current state's weight. If the set cannot be evaluated it emits n results with error set, one
// per cycle. Otherwise it scans for the largest weight, runs the allocation walk (fetching each
// state's weight, stepping into following states, and a fix-up where a pour ends inside a
// state), and then divides each flow by the current weight with a restoring divider at one
// quotient bit per cycle. The weight compare, the walk's subtractions and the divider share one
// subtractor, and the stores are memories with one write port and one registered read port.
// Results appear on o_strobe for exactly one cycle each; the receiver cannot stall them.
// busy falls as the last result is shown.
module weight_allocation_transition_probs
    import watp_pkg::*;
#(
    parameter int MAX_STATES     = MAX_STATES_DEF,
    parameter int WEIGHT_BITS    = WEIGHT_BITS_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [WEIGHT_BITS-1:0]    i_weight,
    input  logic                      i_last_weight,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CUR_BITS-1:0]       i_cfg_data,
    output logic                      o_strobe,
    output logic [PROB_FRAC_BITS:0]   o_probability,
    output logic [STATE_IDX_BITS-1:0] o_state_index,
    output logic                      o_last_result,
    output logic                      o_error
);

    localparam int AW   = $clog2(MAX_STATES);
    localparam int CW   = $clog2(MAX_STATES + 1);
    localparam int W    = WEIGHT_BITS;
    localparam int PF   = PROB_FRAC_BITS;
    localparam int GW   = $clog2(4 * MAX_STATES + 5);
    localparam int BCW  = $clog2(PROB_FRAC_BITS);
    localparam int CMPW = CUR_BITS + 1;
    localparam logic [GW-1:0]  GUARD_LIM = GW'(4 * MAX_STATES + 4);
    localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_STATES);
    localparam logic [BCW-1:0] LAST_BIT  = BCW'(PROB_FRAC_BITS - 1);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_RDCUR  = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_M_RD   = 4'd3;
    localparam logic [3:0] S_M_CMP  = 4'd4;
    localparam logic [3:0] S_P_RDW  = 4'd5;
    localparam logic [3:0] S_P_LDW  = 4'd6;
    localparam logic [3:0] S_P_RDR  = 4'd7;
    localparam logic [3:0] S_P_STEP = 4'd8;
    localparam logic [3:0] S_P_FIX  = 4'd9;
    localparam logic [3:0] S_O_RD   = 4'd10;
    localparam logic [3:0] S_O_INIT = 4'd11;
    localparam logic [3:0] S_O_DIV  = 4'd12;
    localparam logic [3:0] S_E_OUT  = 4'd13;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] idx, input logic [CW-1:0] n);
        logic [CW-1:0] p1;
        p1 = CW'(idx) + CW'(1);
        return (p1 == n) ? '0 : p1[AW-1:0];
    endfunction

    // Memories
    logic [W-1:0] weight_mem [MAX_STATES];
    logic [W-1:0] remain_mem [MAX_STATES];
    logic [W-1:0] flow_mem   [MAX_STATES];

    logic [3:0]            r_state, n_state;
    logic [CUR_BITS-1:0]   r_cur, n_cur;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [CW-1:0]         r_k, n_k;
    logic [AW-1:0]         r_i, n_i;
    logic [AW-1:0]         r_j, n_j;
    logic [AW-1:0]         r_imax, n_imax;
    logic [GW-1:0]         r_guard, n_guard;
    logic [W-1:0]          r_acc, n_acc;
    logic [W-1:0]          r_den, n_den;
    logic [PF:0]           r_q, n_q;
    logic [BCW-1:0]        r_bit, n_bit;
    logic [MAX_STATES-1:0] r_fvalid, n_fvalid;

    logic                  r_strobe, n_strobe;
    logic [PF:0]           r_prob, n_prob;
    logic [AW-1:0]         r_sidx, n_sidx;
    logic                  r_lastr, n_lastr;
    logic                  r_err, n_err;

    // Registered read data
    logic [W-1:0] r_wq, r_rq, r_fq;
    logic         r_fv;

    logic [AW-1:0] rd_addr;
    logic          w_we, r_we, f_we;
    logic [AW-1:0] w_wa, r_wa, f_wa;
    logic [W-1:0]  r_wd, f_wd;

    // Shared subtractor
    logic [W:0]   op_a, op_b;
    logic [W+1:0] sub_res;
    logic         borrow;
    logic [W:0]   diff;

    logic [CW-1:0] k_p1;
    logic [GW-1:0] guard_inc;
    logic          accept, set_err, upd, is_cur, k_last;
    logic [AW-1:0] imax_new;
    logic [W-1:0]  num;

    assign sub_res   = {1'b0, op_a} - {1'b0, op_b};
    assign borrow    = sub_res[W+1];
    assign diff      = sub_res[W:0];
    assign k_p1      = r_k + CW'(1);
    assign k_last    = (k_p1 == r_count);
    assign guard_inc = r_guard + GW'(1);
    assign is_cur    = (r_i == r_cur[AW-1:0]);
    assign accept    = start && !busy;
    assign num       = r_fv ? r_fq : '0;

    assign busy          = (r_state != S_LOAD);
    assign o_cfg_ready   = !busy;
    assign o_strobe      = r_strobe;
    assign o_probability = r_prob;
    assign o_state_index = STATE_IDX_BITS'(r_sidx);
    assign o_last_result = r_lastr;
    assign o_error       = r_err;

    always_comb begin
        case (r_state)
            S_RDCUR: rd_addr = r_cur[AW-1:0];
            S_M_RD:  rd_addr = r_k[AW-1:0];
            S_P_RDW: rd_addr = r_i;
            S_O_RD:  rd_addr = r_k[AW-1:0];
            default: rd_addr = r_j;
        endcase
    end

    always_comb begin
        case (r_state)
            S_M_CMP:  begin op_a = {1'b0, r_acc}; op_b = {1'b0, r_wq};  end
            S_P_STEP: begin op_a = {1'b0, r_acc}; op_b = {1'b0, r_rq};  end
            S_P_FIX:  begin op_a = {1'b0, r_rq};  op_b = {1'b0, r_acc}; end
            S_O_INIT: begin op_a = {1'b0, num};   op_b = {1'b0, r_den}; end
            S_O_DIV:  begin op_a = {r_acc, 1'b0}; op_b = {1'b0, r_den}; end
            default:  begin op_a = '0;            op_b = '0;            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_imax   = r_imax;
        n_guard  = r_guard;
        n_acc    = r_acc;
        n_den    = r_den;
        n_q      = r_q;
        n_bit    = r_bit;
        n_fvalid = r_fvalid;
        n_strobe = 1'b0;
        n_prob   = r_prob;
        n_sidx   = r_sidx;
        n_lastr  = r_lastr;
        n_err    = r_err;
        w_we     = 1'b0;
        r_we     = 1'b0;
        f_we     = 1'b0;
        w_wa     = r_count[AW-1:0];
        r_wa     = r_j;
        f_wa     = r_j;
        r_wd     = '0;
        f_wd     = r_rq;
        set_err  = 1'b0;
        upd      = 1'b0;
        imax_new = r_imax;

        if (i_cfg_valid && o_cfg_ready) begin
            n_cur = i_cfg_data;
        end

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_count < MAX_CNT) begin
                        w_we    = 1'b1;
                        r_we    = 1'b1;
                        r_wa    = r_count[AW-1:0];
                        r_wd    = i_weight;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_weight) begin
                        n_state = S_RDCUR;
                    end
                end
            end
            S_RDCUR: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                set_err  = r_ovf || (CMPW'(r_cur) >= CMPW'(r_count)) || (r_wq == '0);
                n_k      = '0;
                n_den    = r_wq;
                n_fvalid = '0;
                n_state  = set_err ? S_E_OUT : S_M_RD;
            end
            S_M_RD: begin
                n_state = S_M_CMP;
            end
            S_M_CMP: begin
                // Strictly greater keeps the lowest index on a tie
                upd = (r_k == '0) || borrow;
                if (upd) begin
                    n_acc    = r_wq;
                    imax_new = r_k[AW-1:0];
                end
                n_imax = imax_new;
                if (k_last) begin
                    n_i     = imax_new;
                    n_j     = nxt(imax_new, r_count);
                    n_k     = '0;
                    n_guard = '0;
                    n_state = S_P_RDW;
                end else begin
                    n_k     = k_p1;
                    n_state = S_M_RD;
                end
            end
            S_P_RDW: begin
                n_state = S_P_LDW;
            end
            S_P_LDW: begin
                n_acc = r_wq;
                if (r_wq != '0 && r_guard < GUARD_LIM) begin
                    n_state = S_P_RDR;
                end else if (k_last) begin
                    n_k     = '0;
                    n_state = S_O_RD;
                end else begin
                    n_k     = k_p1;
                    n_i     = nxt(r_i, r_count);
                    n_state = S_P_RDW;
                end
            end
            S_P_RDR: begin
                n_state = S_P_STEP;
            end
            S_P_STEP: begin
                n_guard = guard_inc;
                if (!borrow) begin
                    // Fill this state completely and move on
                    if (is_cur) begin
                        f_we              = 1'b1;
                        f_wd              = r_rq;
                        n_fvalid[r_j]     = 1'b1;
                    end
                    r_we  = 1'b1;
                    r_wd  = '0;
                    n_acc = diff[W-1:0];
                    n_j   = nxt(r_j, r_count);
                    if (diff != '0 && guard_inc < GUARD_LIM) begin
                        n_state = S_P_RDR;
                    end else if (k_last) begin
                        n_k     = '0;
                        n_state = S_O_RD;
                    end else begin
                        n_k     = k_p1;
                        n_i     = nxt(r_i, r_count);
                        n_state = S_P_RDW;
                    end
                end else begin
                    if (is_cur) begin
                        f_we          = 1'b1;
                        f_wd          = r_acc;
                        n_fvalid[r_j] = 1'b1;
                    end
                    n_state = S_P_FIX;
                end
            end
            S_P_FIX: begin
                // Pour ends inside this state: shrink its capacity
                r_we  = 1'b1;
                r_wd  = diff[W-1:0];
                n_acc = '0;
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_O_RD;
                end else begin
                    n_k     = k_p1;
                    n_i     = nxt(r_i, r_count);
                    n_state = S_P_RDW;
                end
            end
            S_O_RD: begin
                n_state = S_O_INIT;
            end
            S_O_INIT: begin
                n_q     = {{PF{1'b0}}, !borrow};
                n_acc   = borrow ? num : diff[W-1:0];
                n_bit   = '0;
                n_state = S_O_DIV;
            end
            S_O_DIV: begin
                n_q   = {r_q[PF-1:0], !borrow};
                n_acc = borrow ? {r_acc[W-2:0], 1'b0} : diff[W-1:0];
                n_bit = r_bit + BCW'(1);
                if (r_bit == LAST_BIT) begin
                    n_strobe = 1'b1;
                    n_prob   = {r_q[PF-1:0], !borrow};
                    n_sidx   = r_k[AW-1:0];
                    n_lastr  = k_last;
                    n_err    = 1'b0;
                    if (k_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = k_p1;
                        n_state = S_O_RD;
                    end
                end
            end
            S_E_OUT: begin
                n_strobe = 1'b1;
                n_prob   = '0;
                n_sidx   = r_k[AW-1:0];
                n_lastr  = k_last;
                n_err    = 1'b1;
                if (k_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_k = k_p1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Count saturates at MAX_STATES; the compare above gates both the write and the count
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            weight_mem[w_wa] <= i_weight;
        end
        r_wq <= weight_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            remain_mem[r_wa] <= r_wd;
        end
        r_rq <= remain_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            flow_mem[f_wa] <= f_wd;
        end
        r_fq <= flow_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cur    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_k      <= '0;
            r_fvalid <= '0;
            r_fv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_k      <= n_k;
            r_fvalid <= n_fvalid;
            r_fv     <= r_fvalid[rd_addr];
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_imax  <= n_imax;
        r_guard <= n_guard;
        r_acc   <= n_acc;
        r_den   <= n_den;
        r_q     <= n_q;
        r_bit   <= n_bit;
        r_prob  <= n_prob;
        r_sidx  <= n_sidx;
        r_lastr <= n_lastr;
        r_err   <= n_err;
    end

endmodule

[verif/watp_checker.sv]
`timescale 1ns / 1ps
// Checker: models each weight set, predicts its transition probabilities and compares results.
module watp_checker
    import watp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [WEIGHT_BITS_DEF-1:0]    i_weight,
    input  logic                          i_last_weight,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [CUR_BITS-1:0]           i_cfg_data,
    input  logic                          i_strobe,
    input  logic [PROB_FRAC_BITS_DEF:0]   i_probability,
    input  logic [STATE_IDX_BITS-1:0]     i_state_index,
    input  logic                          i_last_result,
    input  logic                          i_error,
    output int                            o_fail_count,
    output int                            o_open_count
);

    localparam int NS = MAX_STATES_DEF;
    localparam int WB = WEIGHT_BITS_DEF;
    localparam int PB = PROB_FRAC_BITS_DEF;

    typedef struct packed {
        logic [PB:0]                 probability;
        logic [STATE_IDX_BITS-1:0]   state_index;
        logic                        last_result;
        logic                        error;
    } t_prob_result;

    t_prob_result        expected_probs[$];
    logic [WB-1:0]       weight_mem   [NS];
    logic [WB-1:0]       capacity_mem [NS];
    logic [WB-1:0]       flow_mem     [NS];
    int                  loaded;
    bit                  dropped;
    logic [CUR_BITS-1:0] source_state;
    int                  fails = 0;

    assign o_fail_count = fails;

    function automatic int wrap_next(input int idx, input int count);
        return (idx + 1 < count) ? idx + 1 : 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_prob_result  got;
        t_prob_result  want;
        int            n;
        int            imax;
        int            i;
        int            j;
        int            k;
        int            guard;
        logic [WB-1:0] pour;
        logic [63:0]   quot;
        bit            bad;

        if (!i_rst_n) begin
            expected_probs.delete();
            loaded       = 0;
            dropped      = 1'b0;
            source_state = '0;
            o_open_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                source_state = i_cfg_data;

            if (i_strobe) begin
                got = {i_probability, i_state_index, i_last_result, i_error};
                if (expected_probs.size() == 0) begin
                    $display("%0t: result with none expected: expected nothing, got state %0d prob %0d",
                             $time, got.state_index, got.probability);
                    fails++;
                end else begin
                    want = expected_probs.pop_front();
                    if (got.probability !== want.probability) begin
                        $display("%0t: probability: expected %0d, got %0d",
                                 $time, want.probability, got.probability);
                        fails++;
                    end
                    if (got.state_index !== want.state_index) begin
                        $display("%0t: state_index: expected %0d, got %0d",
                                 $time, want.state_index, got.state_index);
                        fails++;
                    end
                    if (got.last_result !== want.last_result) begin
                        $display("%0t: last_result (state %0d): expected %0b, got %0b",
                                 $time, want.state_index, want.last_result, got.last_result);
                        fails++;
                    end
                    if (got.error !== want.error) begin
                        $display("%0t: error (state %0d): expected %0b, got %0b",
                                 $time, want.state_index, want.error, got.error);
                        fails++;
                    end
                end
            end

            if (i_start && !i_busy) begin
                // drop weights past the store depth and remember it
                if (loaded < NS) begin
                    weight_mem[loaded]   = i_weight;
                    capacity_mem[loaded] = i_weight;
                    loaded++;
                end else begin
                    dropped = 1'b1;
                end

                if (i_last_weight) begin
                    n   = loaded;
                    bad = dropped || (int'(source_state) >= n) || (weight_mem[source_state] == '0);
                    for (i = 0; i < NS; i++)
                        flow_mem[i] = '0;
                    if (!bad) begin
                        imax = 0;
                        for (i = 1; i < n; i++)
                            if (weight_mem[i] > weight_mem[imax])
                                imax = i;
                        i     = imax;
                        j     = wrap_next(i, n);
                        guard = 0;
                        // pour each weight into the capacity left in the states after it
                        for (k = 0; k < n; k++) begin
                            pour = weight_mem[i];
                            while (pour != '0 && guard < 4 * NS + 4) begin
                                guard++;
                                if (pour >= capacity_mem[j]) begin
                                    if (i == int'(source_state))
                                        flow_mem[j] = capacity_mem[j];
                                    pour            = pour - capacity_mem[j];
                                    capacity_mem[j] = '0;
                                    j               = wrap_next(j, n);
                                end else begin
                                    if (i == int'(source_state))
                                        flow_mem[j] = pour;
                                    capacity_mem[j] = capacity_mem[j] - pour;
                                    pour            = '0;
                                end
                            end
                            i = wrap_next(i, n);
                        end
                    end
                    for (i = 0; i < n; i++) begin
                        want.probability = '0;
                        if (!bad) begin
                            quot = (64'(flow_mem[i]) << PB) / 64'(weight_mem[source_state]);
                            want.probability = quot[PB:0];
                        end
                        want.state_index = STATE_IDX_BITS'(i);
                        want.last_result = (i == n - 1);
                        want.error       = bad;
                        expected_probs.push_back(want);
                    end
                    loaded  = 0;
                    dropped = 1'b0;
                end
            end
            o_open_count <= expected_probs.size();
        end
    end

endmodule

[verif/tb_weight_allocation_transition_probs.sv]
`timescale 1ns / 1ps
// Testbench top: drives weight sets and current-state writes, and gives the verdict.
module tb_weight_allocation_transition_probs;
    import watp_pkg::*;

    localparam int NS          = MAX_STATES_DEF;
    localparam int WB          = WEIGHT_BITS_DEF;
    localparam int IDLE_LIMIT  = 8000;
    localparam int ITEM_TARGET = 260;

    typedef enum int {STYLE_FULL, STYLE_TINY, STYLE_MIXED, STYLE_FLAT} t_weight_style;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        start         = 1'b0;
    logic [WB-1:0]               i_weight      = '0;
    logic                        i_last_weight = 1'b0;
    logic                        i_cfg_valid   = 1'b0;
    logic [CUR_BITS-1:0]         i_cfg_data    = '0;
    logic                        busy;
    logic                        o_cfg_ready;
    logic                        o_strobe;
    logic [PROB_FRAC_BITS_DEF:0] o_probability;
    logic [STATE_IDX_BITS-1:0]   o_state_index;
    logic                        o_last_result;
    logic                        o_error;

    int            fail_count;
    int            open_count;
    int            items_sent  = 0;
    int            burst_left  = 0;
    int            idle_cycles = 0;
    logic [WB-1:0] set_w [0:NS+5];

    weight_allocation_transition_probs u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_weight      (i_weight),
        .i_last_weight (i_last_weight),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_probability (o_probability),
        .o_state_index (o_state_index),
        .o_last_result (o_last_result),
        .o_error       (o_error)
    );

    watp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_weight      (i_weight),
        .i_last_weight (i_last_weight),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_probability (o_probability),
        .i_state_index (o_state_index),
        .i_last_result (o_last_result),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_open_count  (open_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end the run when no transaction of any kind happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** weight_allocation_transition_probs: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_weight(input logic [WB-1:0] w, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start         <= 1'b1;
        i_weight      <= w;
        i_last_weight <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_weight(set_w[i], i == n - 1);
    endtask

    // Hold off until every result is out and the block is quiet, then write the register
    task automatic write_current(input logic [CUR_BITS-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic fill_set(input int n, input t_weight_style style);
        logic [WB-1:0] common;
        common = WB'($urandom);
        for (int i = 0; i < n; i++) begin
            case (style)
                STYLE_FULL:  set_w[i] = WB'($urandom);
                STYLE_TINY:  set_w[i] = WB'($urandom_range(0, 15));
                STYLE_MIXED: set_w[i] = $urandom_range(0, 1) ? WB'($urandom)
                                                              : WB'($urandom_range(1, 255));
                default:     set_w[i] = common;
            endcase
        end
    endtask

    initial begin : stimulus
        int                  n;
        int                  pick;
        logic [CUR_BITS-1:0] cur;
        bit                  must_write;
        bit                  full_done;
        bit                  overflow_done;

        full_done     = 1'b0;
        overflow_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single state pours into itself
        write_current('0);
        set_w[0] = '1;
        send_set(1);
        // extreme weights, a zero-capacity state
        set_w[0] = '1; set_w[1] = 24'd1; set_w[2] = '0;
        send_set(3);
        // tie for the largest weight, walk wraps around
        write_current(CUR_BITS'(3));
        set_w[0] = 24'd2; set_w[1] = 24'd9; set_w[2] = 24'd4; set_w[3] = 24'd9;
        send_set(4);
        // zero weight at the current state
        write_current(CUR_BITS'(1));
        set_w[0] = 24'd7; set_w[1] = '0; set_w[2] = 24'd3;
        send_set(3);
        // current state beyond the set
        write_current('1);
        set_w[0] = 24'd3; set_w[1] = 24'd4;
        send_set(2);
        write_current(CUR_BITS'(1));
        set_w[0] = 24'd1; set_w[1] = '1;
        send_set(2);

        while (items_sent < ITEM_TARGET) begin
            must_write = 1'b0;
            if (!full_done && items_sent >= 80) begin
                n          = NS;
                cur        = CUR_BITS'(NS - 1);
                must_write = 1'b1;
                full_done  = 1'b1;
            end else if (!overflow_done && items_sent >= 160) begin
                // more weights than the store holds
                n             = NS + int'($urandom_range(1, 2));
                cur           = CUR_BITS'($urandom_range(0, NS - 1));
                overflow_done = 1'b1;
            end else begin
                n    = $urandom_range(1, 8);
                pick = $urandom_range(0, 9);
                cur  = (pick < 8) ? CUR_BITS'($urandom_range(0, n - 1)) : CUR_BITS'($urandom);
            end
            if (must_write || $urandom_range(0, 2) != 0)
                write_current(cur);
            fill_set(n, t_weight_style'($urandom_range(0, 3)));
            send_set(n);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("** weight_allocation_transition_probs: PASSED **");
        else
            $display("** weight_allocation_transition_probs: FAILED **");
        $finish;
    end

endmodule
